### hdl/csa_pkg.sv
// ============================================================================
// csa_pkg: shared definitions for the contiguous slot allocator
// Field widths, status and operation codes, and the control and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package csa_pkg;

    localparam int NUM_SLOTS_DEF = 2048;

    localparam int OP_W     = 1;
    localparam int LEN_W    = 12;
    localparam int FIRST_W  = 11;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 11;

    localparam int WORD_W  = 32;
    localparam int WORD_LG = $clog2(WORD_W);

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_BADARG  = 2'd1;
    localparam t_status ST_NOSPACE = 2'd2;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    typedef struct packed {
        logic    load;
        logic    scan_init;
        logic    mark_init;
        logic    scan_en;
        logic    mark_en;
        logic    set_code;
        t_status code;
        logic    res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic arg_bad;
        logic is_free;
        logic hit;
        logic miss;
        logic mark_done;
        logic out_busy;
    } t_dp_sts;

endpackage

### hdl/csa_ctrl.sv
// ============================================================================
// csa_ctrl: request sequencer
// Accepts one request beat at a time and steps the datapath through the
// argument check, the bitmap scan, the range update and the result.
// ============================================================================
module csa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  csa_pkg::t_dp_sts i_sts,
    output csa_pkg::t_dp_cmd o_cmd
);
    import csa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.code = ST_DONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.arg_bad) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_BADARG;
                    n_state        = S_FIN;
                end else if (i_sts.is_free) begin
                    n_state = S_PREP;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_PREP;
                end else if (i_sts.miss) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_NOSPACE;
                    n_state        = S_FIN;
                end
            end
            S_PREP: begin
                o_cmd.mark_init = 1'b1;
                n_state         = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark_en = 1'b1;
                if (i_sts.mark_done) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_DONE;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/csa_dpath.sv
// ============================================================================
// csa_dpath: bitmap store, word scanner and range writer
// Holds the occupancy bitmap as words in a memory, scans it one word a
// cycle for the first free run and updates a run of slots word by word.
// ============================================================================
module csa_dpath #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csa_pkg::t_dp_cmd              i_cmd,
    output csa_pkg::t_dp_sts              o_sts,
    input  logic [csa_pkg::OP_W-1:0]      i_op,
    input  logic [csa_pkg::LEN_W-1:0]     i_slot_count,
    input  logic [csa_pkg::FIRST_W-1:0]   i_first_slot,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [csa_pkg::STATUS_W-1:0]  o_status,
    output logic [csa_pkg::GRANT_W-1:0]   o_granted_slot
);
    import csa_pkg::*;

    localparam int ROWS     = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_BITS = $clog2(NUM_SLOTS + 1);
    localparam int EXT_W    = ((CNT_BITS > LEN_W) ? CNT_BITS : LEN_W) + 1;
    localparam int RUN_W    = $clog2(WORD_W + 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [EXT_W-1:0] POOL     = EXT_W'(NUM_SLOTS);

    logic [WORD_W-1:0]  r_mem [0:ROWS-1];
    logic [ROWS-1:0]    r_row_vld;
    logic [WORD_W-1:0]  r_rd_data;
    logic               r_rd_vld;

    logic [OP_W-1:0]    r_op;
    logic [LEN_W-1:0]   r_len;
    logic [FIRST_W-1:0] r_first;
    logic [EXT_W-1:0]   r_start;
    logic [EXT_W-1:0]   r_carry;
    t_status            r_code;

    logic [ROW_W-1:0]   r_rd_row;
    logic [ROW_W-1:0]   r_ev_row;
    logic               r_issue;
    logic               r_dv;

    logic               r_out_vld;
    t_status            r_out_status;
    logic [GRANT_W-1:0] r_out_grant;

    logic [EXT_W-1:0]   len_ext;
    logic [EXT_W-1:0]   first_ext;
    logic [EXT_W-1:0]   end_slot;
    logic [ROW_W-1:0]   srow;
    logic [ROW_W-1:0]   erow;
    logic [ROW_W-1:0]   stop_row;
    logic               step;
    logic               rd_en;

    logic [WORD_W-1:0]  old_word;
    logic [WORD_W-1:0]  free_bits;
    logic [RUN_W-1:0]   run_a [WORD_W];
    logic [RUN_W-1:0]   run_b [WORD_W];
    logic [EXT_W-1:0]   eff [WORD_W];
    logic [EXT_W-1:0]   slot_idx;
    logic               any_hit;
    logic [WORD_LG-1:0] hit_pos;
    logic [EXT_W-1:0]   hit_start;
    logic [EXT_W-1:0]   n_carry;

    logic [WORD_LG-1:0] lo_bit;
    logic [WORD_LG-1:0] hi_bit;
    logic [WORD_W-1:0]  wr_mask;
    logic [WORD_W-1:0]  wr_data;
    logic               wr_en;

    assign len_ext   = EXT_W'(r_len);
    assign first_ext = EXT_W'(r_first);
    assign end_slot  = r_start + len_ext - EXT_W'(1);
    assign srow      = r_start[ROW_W+WORD_LG-1:WORD_LG];
    assign erow      = end_slot[ROW_W+WORD_LG-1:WORD_LG];
    assign stop_row  = i_cmd.scan_en ? LAST_ROW : erow;
    assign step      = i_cmd.scan_en | i_cmd.mark_en;
    assign rd_en     = step & r_issue;
    assign old_word  = r_rd_vld ? r_rd_data : '0;

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            slot_idx     = (EXT_W'(r_ev_row) << WORD_LG) + EXT_W'(b);
            free_bits[b] = ~old_word[b] & (slot_idx < POOL);
        end
    end

    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            run_a[j] = RUN_W'(free_bits[j]);
            run_b[j] = '0;
        end
        for (int l = 0; l < WORD_LG; l++) begin
            for (int j = 0; j < WORD_W; j++) begin
                if (j >= (1 << l) && run_a[j] == RUN_W'(1 << l)) begin
                    run_b[j] = run_a[j] + run_a[j - (1 << l)];
                end else begin
                    run_b[j] = run_a[j];
                end
            end
            for (int j = 0; j < WORD_W; j++) begin
                run_a[j] = run_b[j];
            end
        end
    end

    always_comb begin
        any_hit = 1'b0;
        hit_pos = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (run_a[j] == RUN_W'(j + 1)) begin
                eff[j] = r_carry + EXT_W'(j + 1);
            end else begin
                eff[j] = EXT_W'(run_a[j]);
            end
        end
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (eff[j] >= len_ext) begin
                any_hit = 1'b1;
                hit_pos = WORD_LG'(j);
            end
        end
        hit_start = (EXT_W'(r_ev_row) << WORD_LG) + EXT_W'(hit_pos) + EXT_W'(1) - len_ext;
        n_carry   = (eff[WORD_W-1] >= len_ext) ? len_ext : eff[WORD_W-1];
    end

    always_comb begin
        lo_bit  = (r_ev_row == srow) ? r_start[WORD_LG-1:0] : '0;
        hi_bit  = (r_ev_row == erow) ? end_slot[WORD_LG-1:0] : '1;
        wr_mask = ({WORD_W{1'b1}} << lo_bit)
                & ({WORD_W{1'b1}} >> (WORD_LG'(WORD_W - 1) - hi_bit));
        wr_data = (r_op == OP_FREE) ? (old_word & ~wr_mask) : (old_word | wr_mask);
        wr_en   = i_cmd.mark_en & r_dv;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_row];
            r_rd_vld  <= r_row_vld[r_rd_row];
        end
        if (wr_en) begin
            r_mem[r_ev_row] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_issue   <= 1'b0;
            r_dv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[r_ev_row] <= 1'b1;
            end
            if (i_cmd.scan_init || i_cmd.mark_init) begin
                r_issue <= 1'b1;
                r_dv    <= 1'b0;
            end else if (step) begin
                r_dv <= r_issue;
                if (r_issue) begin
                    r_issue <= (r_rd_row != stop_row);
                end
            end else begin
                r_dv <= 1'b0;
            end
            if (i_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_len   <= i_slot_count;
            r_first <= i_first_slot;
            r_start <= EXT_W'(i_first_slot);
        end
        if (i_cmd.scan_init) begin
            r_rd_row <= '0;
            r_carry  <= '0;
        end else if (i_cmd.mark_init) begin
            r_rd_row <= srow;
        end else if (rd_en) begin
            r_rd_row <= r_rd_row + ROW_W'(1);
            r_ev_row <= r_rd_row;
        end
        if (i_cmd.scan_en && r_dv) begin
            r_carry <= n_carry;
            if (any_hit) begin
                r_start <= hit_start;
            end
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
        if (i_cmd.res_load) begin
            r_out_status <= r_code;
            if (r_code == ST_DONE && r_op == OP_ALLOC) begin
                r_out_grant <= r_start[GRANT_W-1:0];
            end else begin
                r_out_grant <= '0;
            end
        end
    end

    always_comb begin
        o_sts.is_free = (r_op == OP_FREE);
        if (r_op == OP_FREE) begin
            o_sts.arg_bad = (r_len == '0) || (first_ext >= POOL)
                          || (len_ext > POOL - first_ext);
        end else begin
            o_sts.arg_bad = (r_len == '0) || (len_ext > POOL);
        end
        o_sts.hit       = i_cmd.scan_en & r_dv & any_hit;
        o_sts.miss      = i_cmd.scan_en & r_dv & ~any_hit & (r_ev_row == LAST_ROW);
        o_sts.mark_done = i_cmd.mark_en & r_dv & (r_ev_row == erow);
        o_sts.out_busy  = r_out_vld & ~i_out_ready;
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_grant;

endmodule

### hdl/contiguous_slot_allocator_unit.sv
// Per request beat: a bad argument goes straight to the result, a free writes R words, a
// successful allocate scans S words and then writes R words, and when no run fits all W words
// are scanned; W = ceil(NUM_SLOTS/32) bitmap words, one word read per cycle.
// One request at a time: the next beat is taken in the cycle after the result is loaded, and
// a result beat still waiting holds back the next result, not the next request beat.
// Synchronous active-low reset clears the per-word valid bits, so every slot is free.
// ============================================================================
// contiguous_slot_allocator_unit: first-fit contiguous slot allocator
// Allocates and frees runs of slots in an occupancy bitmap, one request at a time.
// ============================================================================
module contiguous_slot_allocator_unit #(
    parameter int NUM_SLOTS = csa_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [csa_pkg::OP_W-1:0]      i_op,
    input  logic [csa_pkg::LEN_W-1:0]     i_slot_count,
    input  logic [csa_pkg::FIRST_W-1:0]   i_first_slot,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [csa_pkg::STATUS_W-1:0]  o_status,
    output logic [csa_pkg::GRANT_W-1:0]   o_granted_slot
);
    import csa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    csa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    csa_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_op),
        .i_slot_count   (i_slot_count),
        .i_first_slot   (i_first_slot),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot)
    );

`ifndef SYNTH
    a_grant_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DONE) |-> (o_granted_slot == '0))
        else $error("granted slot set on a failed request");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_DONE || o_status == ST_BADARG
                     || o_status == ST_NOSPACE))
        else $error("illegal status code");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request beat taken while a request is in progress");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.scan_en && cmd.mark_en))
        else $error("scan and range update active together");
`endif

endmodule
